FILE: sv/llfb_pkg.sv
package llfb_pkg;

    // Sizing
    localparam int MAX_FRAMES  = 8;
    localparam int LINEAR_BITS = 16;
    localparam int CH_NUM      = 3;
    localparam int CFG_W       = 4;
    localparam int FC_W        = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W       = LINEAR_BITS + $clog2(MAX_FRAMES);
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int FWD_DEPTH   = 256;
    localparam int INV_DEPTH   = 1 << LINEAR_BITS;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int PEND_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [LINEAR_BITS-1:0] LIN_MAX      = {LINEAR_BITS{1'b1}};
    localparam logic [7:0]             ALPHA_OPAQUE = 8'hff;

    // Request kinds carried on tuser
    localparam logic [1:0] ACT_BLEND  = 2'd0;
    localparam logic [1:0] ACT_FWD_WR = 2'd1;
    localparam logic [1:0] ACT_INV_WR = 2'd2;

    // Table write broadcast
    typedef struct packed {
        logic        fwd_en;
        logic        inv_en;
        logic [15:0] addr;
        logic [15:0] data;
    } t_tbl_wr;

    // What one frame lane found
    typedef struct packed {
        logic                                on;
        logic                                match;
        logic [CH_NUM-1:0][LINEAR_BITS-1:0]  lin;
    } t_lane_out;

    // Per-request control traveling beside the lanes
    typedef struct packed {
        logic               valid;
        logic               pass;
        logic [RECIP_W-1:0] recip;
        logic [31:0]        pix0;
    } t_blend_ctl;

    // Finished result
    typedef struct packed {
        logic [31:0] pixel;
        logic        is_static;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_result;

    // ceil(2^32 / n) for the blend divide
    function automatic logic [RECIP_W-1:0] recip_of(input logic [FC_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            FC_W'(2): r = 32'h8000_0000;
            FC_W'(3): r = 32'h5555_5556;
            FC_W'(4): r = 32'h4000_0000;
            FC_W'(5): r = 32'h3333_3334;
            FC_W'(6): r = 32'h2aaa_aaab;
            FC_W'(7): r = 32'h2492_4925;
            FC_W'(8): r = 32'h2000_0000;
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/llfb_lane.sv
module llfb_lane (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic                i_lane_on,
    input  logic [31:0]         i_pixel,
    input  logic [23:0]         i_ref_colour,
    input  llfb_pkg::t_tbl_wr   i_wr,
    output llfb_pkg::t_lane_out o_lane
);
    import llfb_pkg::*;

    // Two copies of the forward table: copy A serves channels 0 and 1, copy B channel 2
    logic [LINEAR_BITS-1:0] r_fwd_a [FWD_DEPTH];
    logic [LINEAR_BITS-1:0] r_fwd_b [FWD_DEPTH];
    t_lane_out              r_lane;

    // Write both copies from the broadcast
    always_ff @(posedge i_clk) begin
        if (i_wr.fwd_en) begin
            r_fwd_a[i_wr.addr[7:0]] <= i_wr.data[LINEAR_BITS-1:0];
            r_fwd_b[i_wr.addr[7:0]] <= i_wr.data[LINEAR_BITS-1:0];
        end
    end

    // Look up all three channels and compare colour against the newest frame
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_lane.lin[0] <= r_fwd_a[i_pixel[7:0]];
            r_lane.lin[1] <= r_fwd_a[i_pixel[15:8]];
            r_lane.lin[2] <= r_fwd_b[i_pixel[23:16]];
            r_lane.on     <= i_lane_on;
            r_lane.match  <= !i_lane_on || (i_pixel[23:0] == i_ref_colour);
        end
    end

    assign o_lane = r_lane;

endmodule

FILE: sv/llfb_merge.sv
module llfb_merge (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  llfb_pkg::t_blend_ctl                           i_ctl,
    input  llfb_pkg::t_lane_out [llfb_pkg::MAX_FRAMES-1:0] i_lane,
    input  llfb_pkg::t_tbl_wr                              i_wr,
    output llfb_pkg::t_result                              o_res
);
    import llfb_pkg::*;

    // Sum stage
    t_blend_ctl                   r_b_ctl;
    logic                         r_b_static;
    logic [CH_NUM-1:0][SUM_W-1:0] r_b_sum;
    logic [CH_NUM-1:0][SUM_W-1:0] n_b_sum;
    logic                         n_b_static;

    // Scale stage
    t_blend_ctl                   r_c_ctl;
    logic                         r_c_static;
    logic [CH_NUM-1:0][SUM_W-1:0] r_c_avg;
    logic [CH_NUM-1:0][PROD_W-1:0] w_prod;

    // Inverse lookup stage
    t_blend_ctl                         r_d_ctl;
    logic                               r_d_static;
    logic [CH_NUM-1:0][7:0]             r_d_byte;
    logic [CH_NUM-1:0][LINEAR_BITS-1:0] w_inv_addr;

    // Inverse writes delayed to the lookup stage
    t_tbl_wr                            r_wr_b;
    t_tbl_wr                            r_wr_c;
    t_tbl_wr                            r_wr_d;

    // Two copies of the inverse table: copy A serves channels 0 and 1, copy B channel 2
    logic [7:0] r_inv_a [INV_DEPTH];
    logic [7:0] r_inv_b [INV_DEPTH];

    // Add lane contributions per channel, and fold the lane matches
    always_comb begin
        n_b_sum    = '0;
        n_b_static = 1'b1;
        for (int f = 0; f < MAX_FRAMES; f++) begin
            n_b_static = n_b_static & i_lane[f].match;
            for (int c = 0; c < CH_NUM; c++) begin
                if (i_lane[f].on) begin
                    n_b_sum[c] = n_b_sum[c] + SUM_W'(i_lane[f].lin[c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl.valid <= 1'b0;
        end else begin
            r_b_ctl.valid <= i_ctl.valid;
        end
        r_b_ctl.pass  <= i_ctl.pass;
        r_b_ctl.recip <= i_ctl.recip;
        r_b_ctl.pix0  <= i_ctl.pix0;
        r_b_static    <= n_b_static;
        r_b_sum       <= n_b_sum;
    end

    // Divide by frame count through the reciprocal, keep the high word
    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            w_prod[c] = PROD_W'(r_b_sum[c]) * PROD_W'(r_b_ctl.recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl.valid <= 1'b0;
        end else begin
            r_c_ctl.valid <= r_b_ctl.valid;
        end
        r_c_ctl.pass  <= r_b_ctl.pass;
        r_c_ctl.recip <= r_b_ctl.recip;
        r_c_ctl.pix0  <= r_b_ctl.pix0;
        r_c_static    <= r_b_static;
        for (int c = 0; c < CH_NUM; c++) begin
            r_c_avg[c] <= w_prod[c][PROD_W-1:RECIP_W];
        end
    end

    // Clamp to the linear range to form the inverse table address
    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            if (r_c_avg[c] > SUM_W'(LIN_MAX)) begin
                w_inv_addr[c] = LIN_MAX;
            end else begin
                w_inv_addr[c] = r_c_avg[c][LINEAR_BITS-1:0];
            end
        end
    end

    // Carry each write through r_wr_b, r_wr_c and r_wr_d so it lands after older lookups and before newer ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_b <= '0;
            r_wr_c <= '0;
            r_wr_d <= '0;
        end else begin
            r_wr_b <= i_wr;
            r_wr_c <= r_wr_b;
            r_wr_d <= r_wr_c;
        end
    end

    // Write both inverse copies from the delayed broadcast
    always_ff @(posedge i_clk) begin
        if (r_wr_d.inv_en) begin
            r_inv_a[r_wr_d.addr[LINEAR_BITS-1:0]] <= r_wr_d.data[7:0];
            r_inv_b[r_wr_d.addr[LINEAR_BITS-1:0]] <= r_wr_d.data[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_ctl.valid) begin
            r_d_byte[0] <= r_inv_a[w_inv_addr[0]];
            r_d_byte[1] <= r_inv_a[w_inv_addr[1]];
            r_d_byte[2] <= r_inv_b[w_inv_addr[2]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl.valid <= 1'b0;
        end else begin
            r_d_ctl.valid <= r_c_ctl.valid;
        end
        r_d_ctl.pass  <= r_c_ctl.pass;
        r_d_ctl.recip <= r_c_ctl.recip;
        r_d_ctl.pix0  <= r_c_ctl.pix0;
        r_d_static    <= r_c_static;
    end

    // Pick passthrough, static colour or blended colour
    always_comb begin
        o_res.valid          = r_d_ctl.valid;
        o_res.data.is_static = r_d_ctl.pass | r_d_static;
        if (r_d_ctl.pass) begin
            o_res.data.pixel = r_d_ctl.pix0;
        end else if (r_d_static) begin
            o_res.data.pixel = {ALPHA_OPAQUE, r_d_ctl.pix0[23:0]};
        end else begin
            o_res.data.pixel = {ALPHA_OPAQUE, r_d_byte[2], r_d_byte[1], r_d_byte[0]};
        end
    end

endmodule

FILE: sv/llfb_fifo.sv
module llfb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  llfb_pkg::t_out i_data,
    input  logic           i_pop,
    output logic           o_valid,
    output llfb_pkg::t_out o_data
);
    import llfb_pkg::*;

    t_out               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [PEND_W-1:0]  r_count;
    logic [FIFO_AW-1:0] n_wr_ptr;
    logic [FIFO_AW-1:0] n_rd_ptr;
    logic [PEND_W-1:0]  n_count;
    logic               w_pop;

    assign w_pop = i_pop && (r_count != '0);

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

FILE: sv/linear_light_frame_blend_core.sv
// Linear-light frame blend.
// Slave stream: one request per accepted beat. tuser carries the request kind
// (blend a pixel, write a forward table entry, write an inverse table entry);
// tdata carries the table address, the table data and the same pixel position
// from the eight newest frames, frame 0 the newest. Table writes give no result.
// Master stream: one result per blend request, the blended pixel on tdata and
// the static flag on tuser, in request order.
// Configuration: i_cfg_wen writes the frame count from i_cfg_wdata; write it
// only while no blend request is outstanding.
// Path: a blend request passes through lane lookup, sum, reciprocal multiply,
// inverse lookup and the output queue before it shows on the master side.
// Throughput: one request per cycle while tready is high, with eight frame
// lanes working side by side on each request.
// Back-pressure: results wait in an eight-entry output queue; tready on the
// slave side drops only when eight blend results are in flight or queued, so a
// stalled receiver holds the block after the queue fills, and nothing is lost.
// Reset: clears the pipeline, the queue and sets the frame count to 1. Both
// tables come up unwritten and must be loaded before blending.
module linear_light_frame_blend_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration
    input  logic         i_cfg_wen,
    input  logic [3:0]   i_cfg_wdata,
    // Requests
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [15:0] table_addr, [31:16] table_data, [63:32] frame_pixel_0,
    // [95:64] frame_pixel_1, ... [287:256] frame_pixel_7
    input  logic [287:0] i_s_axis_tdata,
    // [1:0] action
    input  logic [1:0]   i_s_axis_tuser,
    // Results
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] blended_pixel
    output logic [31:0]  o_m_axis_tdata,
    // [0] was_static
    output logic         o_m_axis_tuser
);
    import llfb_pkg::*;

    localparam logic [16:0] INV_LIMIT = 17'(INV_DEPTH);

    logic [CFG_W-1:0]  r_frame_count;
    logic [FC_W-1:0]   w_n_used;
    logic [PEND_W-1:0] r_pending;
    logic [PEND_W-1:0] n_pending;
    logic              w_s_acc;
    logic              w_m_acc;
    logic              w_blend_acc;
    logic [15:0]       w_addr;
    logic [15:0]       w_data;
    t_tbl_wr           w_wr;
    t_blend_ctl        r_a_ctl;
    t_lane_out [MAX_FRAMES-1:0] w_lane;
    t_result           w_res;
    t_out              w_q_data;

    assign w_addr      = i_s_axis_tdata[15:0];
    assign w_data      = i_s_axis_tdata[31:16];
    assign w_s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_m_acc     = o_m_axis_tvalid && i_m_axis_tready;
    assign w_blend_acc = w_s_acc && (i_s_axis_tuser == ACT_BLEND);

    // Hold frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= CFG_W'(1);
        end else if (i_cfg_wen) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    // Clamp frame count into 1..MAX_FRAMES
    always_comb begin
        if (r_frame_count == '0) begin
            w_n_used = FC_W'(1);
        end else if (r_frame_count > CFG_W'(MAX_FRAMES)) begin
            w_n_used = FC_W'(MAX_FRAMES);
        end else begin
            w_n_used = FC_W'(r_frame_count);
        end
    end

    // Decode table writes, drop out-of-range addresses
    always_comb begin
        w_wr.fwd_en = w_s_acc && (i_s_axis_tuser == ACT_FWD_WR) && (w_addr[15:8] == '0);
        w_wr.inv_en = w_s_acc && (i_s_axis_tuser == ACT_INV_WR) && ({1'b0, w_addr} < INV_LIMIT);
        w_wr.addr   = w_addr;
        w_wr.data   = w_data;
    end

    // Count blend requests not yet delivered; bounds the output queue
    always_comb begin
        n_pending = r_pending;
        if (w_blend_acc && !w_m_acc) begin
            n_pending = r_pending + 1'b1;
        end else if (!w_blend_acc && w_m_acc) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    assign o_s_axis_tready = (r_pending < PEND_W'(FIFO_DEPTH));

    // Capture request control beside the lane lookups
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
        end else begin
            r_a_ctl.valid <= w_blend_acc;
        end
        if (w_blend_acc) begin
            r_a_ctl.pass  <= (w_n_used == FC_W'(1));
            r_a_ctl.recip <= recip_of(w_n_used);
            r_a_ctl.pix0  <= i_s_axis_tdata[63:32];
        end
    end

    // Frame lanes
    for (genvar f = 0; f < MAX_FRAMES; f++) begin : g_lane
        llfb_lane u_lane (
            .i_clk        (i_clk),
            .i_rd_en      (w_blend_acc),
            .i_lane_on    (FC_W'(f) < w_n_used),
            .i_pixel      (i_s_axis_tdata[32*f+63 -: 32]),
            .i_ref_colour (i_s_axis_tdata[55:32]),
            .i_wr         (w_wr),
            .o_lane       (w_lane[f])
        );
    end

    llfb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_a_ctl),
        .i_lane  (w_lane),
        .i_wr    (w_wr),
        .o_res   (w_res)
    );

    llfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res.valid),
        .i_data  (w_res.data),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_q_data)
    );

    assign o_m_axis_tdata = w_q_data.pixel;
    assign o_m_axis_tuser = w_q_data.is_static;

`ifndef SYNTH
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(FIFO_DEPTH))
        else $error("outstanding request count above queue depth");

    a_res_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_pending != '0))
        else $error("blend result without an outstanding request");

    a_out_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pending != '0))
        else $error("queued result without an outstanding request");

    a_both_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_res.valid) |-> (r_pending >= PEND_W'(2)))
        else $error("queue and pipeline hold more results than counted");
`endif

endmodule
